// ===== hw/rtl/socl_pkg.sv =====
package socl_pkg;

   localparam int IN_DIM_W    = 11;
   localparam int CELL_W      = 21;
   localparam int MAX_DIM_DEF = 1024;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   // walk directions
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_INIT,
      ST_LEG,
      ST_MUL,
      ST_SUM,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/spiral_order_cell_locator.sv =====
// Spiral cell locator: each request beat names a grid (rows x cols, cells numbered row-major
// from 1), a turn sense, a start corner and a one-based step count; the response beat carries
// the number of the cell reached at that step of a spiral walk from the corner inward, or
// range_error with cell 0 when the step count is zero or beyond rows x cols, or a dimension is
// zero or above MAX_DIM. One request is worked on at a time: req_tready is high only while the
// block is idle. The leg loop walks one spiral leg per cycle, at most rows + cols legs, with one
// shared position adder; a single shared multiplier forms both rows x cols and the final
// row x cols product. The response then waits in its register until rsp_tready.
module spiral_order_cell_locator #(
   parameter int MAX_DIM = socl_pkg::MAX_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [10:0] grid_rows, [21:11] grid_cols, [22] counter_clockwise, [24:23] start_corner,
   // [45:25] step_count, [47:46] zero
   input  logic [socl_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [20:0] cell_number, [23:21] zero
   output logic [socl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] range_error
   output logic                              rsp_tuser
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int POS_W  = DIM_W + 1;
   localparam int PROD_W = 2 * DIM_W;
   localparam int CMP_W  = (PROD_W > socl_pkg::CELL_W) ? PROD_W : socl_pkg::CELL_W;
   localparam int LEN_W  = (POS_W > socl_pkg::CELL_W) ? POS_W : socl_pkg::CELL_W;

   socl_pkg::state_type state_ff, state_in;

   logic [socl_pkg::IN_DIM_W-1:0] rows_ff, rows_in;
   logic [socl_pkg::IN_DIM_W-1:0] cols_ff, cols_in;
   logic                          ccw_ff, ccw_in;
   logic [1:0]                    corner_ff, corner_in;
   logic [socl_pkg::CELL_W-1:0]   k_ff, k_in;
   logic [1:0]                    dir_ff, dir_in;
   logic signed [POS_W-1:0]       r_ff, r_in;
   logic signed [POS_W-1:0]       c_ff, c_in;
   logic signed [POS_W-1:0]       hlen_ff, hlen_in;
   logic signed [POS_W-1:0]       vlen_ff, vlen_in;
   logic [PROD_W-1:0]             mul_ff, mul_in;
   logic [socl_pkg::CELL_W-1:0]   cell_ff, cell_in;
   logic                          err_ff, err_in;

   // shared units
   logic [DIM_W-1:0]              mul_a, mul_b;
   logic signed [POS_W-1:0]       len, mv, base, sum;
   logic                          hit;
   logic                          dims_ok;
   logic signed [POS_W-1:0]       rows_s, cols_s, r0, c0;
   logic [1:0]                    dir0;

   assign rows_s = $signed({1'b0, DIM_W'(rows_ff)});
   assign cols_s = $signed({1'b0, DIM_W'(cols_ff)});
   assign dims_ok = (rows_ff != '0) && (cols_ff != '0) &&
                    (int'(rows_ff) <= MAX_DIM) && (int'(cols_ff) <= MAX_DIM);

   assign len  = dir_ff[0] ? vlen_ff : hlen_ff;
   assign hit  = !len[POS_W-1] &&
                 (LEN_W'(k_ff) <= LEN_W'($unsigned(len)));
   assign mv   = hit ? $signed(POS_W'(k_ff)) : len;
   assign base = dir_ff[0] ? r_ff : c_ff;
   assign sum  = dir_ff[1] ? (base - mv) : (base + mv);

   assign dir0 = ccw_ff ? (corner_ff + 2'd1) : corner_ff;
   assign r0   = corner_ff[1] ? (rows_s - POS_W'(1)) : '0;
   assign c0   = (corner_ff[0] ^ corner_ff[1]) ? (cols_s - POS_W'(1)) : '0;

   always_comb begin
      mul_a = (state_ff == socl_pkg::ST_MUL) ? r_ff[DIM_W-1:0] : DIM_W'(rows_ff);
      mul_b = DIM_W'(cols_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= socl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff   <= rows_in;
      cols_ff   <= cols_in;
      ccw_ff    <= ccw_in;
      corner_ff <= corner_in;
      k_ff      <= k_in;
      dir_ff    <= dir_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      hlen_ff   <= hlen_in;
      vlen_ff   <= vlen_in;
      mul_ff    <= mul_in;
      cell_ff   <= cell_in;
      err_ff    <= err_in;
   end

   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      ccw_in    = ccw_ff;
      corner_in = corner_ff;
      k_in      = k_ff;
      dir_in    = dir_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      hlen_in   = hlen_ff;
      vlen_in   = vlen_ff;
      mul_in    = mul_ff;
      cell_in   = cell_ff;
      err_in    = err_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         socl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rows_in   = req_tdata[10:0];
               cols_in   = req_tdata[21:11];
               ccw_in    = req_tdata[22];
               corner_in = req_tdata[24:23];
               k_in      = req_tdata[45:25];
               state_in  = socl_pkg::ST_AREA;
            end
         end
         socl_pkg::ST_AREA: begin
            mul_in   = mul_a * mul_b;
            state_in = socl_pkg::ST_INIT;
         end
         socl_pkg::ST_INIT: begin
            if (!dims_ok || (k_ff == '0) || (CMP_W'(k_ff) > CMP_W'(mul_ff))) begin
               cell_in  = '0;
               err_in   = 1'b1;
               state_in = socl_pkg::ST_RESP;
            end else begin
               dir_in  = dir0;
               hlen_in = cols_s;
               vlen_in = rows_s;
               r_in    = r0;
               c_in    = c0;
               // back up one cell so the first leg lands on the corner
               case (dir0)
                  socl_pkg::DIR_RIGHT: c_in = c0 - POS_W'(1);
                  socl_pkg::DIR_DOWN:  r_in = r0 - POS_W'(1);
                  socl_pkg::DIR_LEFT:  c_in = c0 + POS_W'(1);
                  socl_pkg::DIR_UP:    r_in = r0 + POS_W'(1);
                  default:             r_in = r0;
               endcase
               if (dir0[0]) begin
                  hlen_in = cols_s - POS_W'(1);
               end else begin
                  vlen_in = rows_s - POS_W'(1);
               end
               state_in = socl_pkg::ST_LEG;
            end
         end
         socl_pkg::ST_LEG: begin
            if (len[POS_W-1]) begin
               cell_in  = '0;
               err_in   = 1'b1;
               state_in = socl_pkg::ST_RESP;
            end else begin
               if (dir_ff[0]) begin
                  r_in = sum;
               end else begin
                  c_in = sum;
               end
               if (hit) begin
                  state_in = socl_pkg::ST_MUL;
               end else begin
                  k_in = k_ff - socl_pkg::CELL_W'($unsigned(len));
                  if (dir_ff[0]) begin
                     vlen_in = vlen_ff - POS_W'(1);
                  end else begin
                     hlen_in = hlen_ff - POS_W'(1);
                  end
                  dir_in = ccw_ff ? (dir_ff - 2'd1) : (dir_ff + 2'd1);
               end
            end
         end
         socl_pkg::ST_MUL: begin
            mul_in = mul_a * mul_b;
            if (r_ff[POS_W-1] || c_ff[POS_W-1] || (r_ff >= rows_s) || (c_ff >= cols_s)) begin
               cell_in  = '0;
               err_in   = 1'b1;
               state_in = socl_pkg::ST_RESP;
            end else begin
               state_in = socl_pkg::ST_SUM;
            end
         end
         socl_pkg::ST_SUM: begin
            cell_in  = socl_pkg::CELL_W'(mul_ff) +
                       socl_pkg::CELL_W'($unsigned(c_ff)) + socl_pkg::CELL_W'(1);
            err_in   = 1'b0;
            state_in = socl_pkg::ST_RESP;
         end
         socl_pkg::ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = socl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = socl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = {{(socl_pkg::RSP_DATA_W - socl_pkg::CELL_W){1'b0}}, cell_ff};
   assign rsp_tuser = err_ff;

   // an error beat always carries cell 0
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error beat with nonzero cell");

   // a good beat never carries cell 0
   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata != '0)
      else $error("good beat with cell 0");

   // no new request while a response is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while response pending");

   // an accepted request is followed by the range check via the multiplier
   a_accept_area: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == socl_pkg::ST_AREA)
      else $error("accept did not start area step");

   // after the leg that holds the step, the position does not exceed rows or cols
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == socl_pkg::ST_LEG && hit |=> (r_ff <= rows_s) && (c_ff <= cols_s))
      else $error("position beyond grid");

endmodule

// ===== tb/spiral_cell_checker.sv =====
module spiral_cell_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [socl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [socl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   output int                              mismatch_total,
   output int                              outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM = socl_pkg::MAX_DIM_DEF;

   typedef struct packed {
      logic [socl_pkg::CELL_W-1:0] cell_number;
      logic                        range_error;
   } cell_result_type;

   cell_result_type expected_cells[$];

   initial begin
      mismatch_total = 0;
      outstanding    = 0;
   end

   function automatic int row_delta(input logic [1:0] dir);
      case (dir)
         socl_pkg::DIR_DOWN: return 1;
         socl_pkg::DIR_UP:   return -1;
         default:            return 0;
      endcase
   endfunction

   function automatic int col_delta(input logic [1:0] dir);
      case (dir)
         socl_pkg::DIR_RIGHT: return 1;
         socl_pkg::DIR_LEFT:  return -1;
         default:             return 0;
      endcase
   endfunction

   // Walks the spiral one leg at a time until the leg that holds the target step.
   function automatic cell_result_type locate_cell(
         input logic [socl_pkg::IN_DIM_W-1:0] rows,
         input logic [socl_pkg::IN_DIM_W-1:0] cols,
         input logic ccw,
         input logic [1:0] corner,
         input logic [socl_pkg::CELL_W-1:0] step);
      cell_result_type res;
      longint          nr, nc, r, c, hlen, vlen, len, left;
      logic [1:0]      dir;
      logic            horiz;
      int              leg;
      res.cell_number = '0;
      res.range_error = 1'b1;
      nr   = longint'(rows);
      nc   = longint'(cols);
      left = longint'(step);
      if (nr == 0 || nc == 0 || nr > MAX_DIM || nc > MAX_DIM) return res;
      if (left == 0 || left > nr * nc) return res;
      dir = ccw ? corner + 2'd1 : corner;
      r = (corner >= 2'd2) ? nr - 1 : 0;
      c = (corner == 2'd1 || corner == 2'd2) ? nc - 1 : 0;
      // start one cell outside the corner so the first leg covers the corner itself
      r -= row_delta(dir);
      c -= col_delta(dir);
      hlen = nc;
      vlen = nr;
      if (dir[0]) hlen--;
      else vlen--;
      for (leg = 0; leg < 2 * MAX_DIM + 4; leg++) begin
         horiz = !dir[0];
         len   = horiz ? hlen : vlen;
         if (len < 0) break;
         if (left <= len) begin
            r += row_delta(dir) * left;
            c += col_delta(dir) * left;
            if (r >= 0 && c >= 0 && r < nr && c < nc) begin
               res.cell_number = socl_pkg::CELL_W'(r * nc + c + 1);
               res.range_error = 1'b0;
            end
            return res;
         end
         r    += row_delta(dir) * len;
         c    += col_delta(dir) * len;
         left -= len;
         if (horiz) hlen--;
         else vlen--;
         dir = ccw ? dir - 2'd1 : dir + 2'd1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_total++;
      $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      cell_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cells.size() == 0) begin
               report_mismatch("unexpected rsp beat, cell_number",
                               int'(rsp_tdata[socl_pkg::CELL_W-1:0]), 0);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tdata[socl_pkg::CELL_W-1:0] !== want.cell_number)
                  report_mismatch("cell_number", int'(rsp_tdata[socl_pkg::CELL_W-1:0]),
                                  int'(want.cell_number));
               if (rsp_tuser !== want.range_error)
                  report_mismatch("range_error", int'(rsp_tuser), int'(want.range_error));
            end
         end
         if (req_tvalid && req_tready)
            expected_cells.push_back(locate_cell(req_tdata[10:0], req_tdata[21:11],
                                                 req_tdata[22], req_tdata[24:23],
                                                 req_tdata[45:25]));
      end
      outstanding <= expected_cells.size();
   end

endmodule

// ===== tb/spiral_order_cell_locator_tb.sv =====
module spiral_order_cell_locator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM    = socl_pkg::MAX_DIM_DEF;
   localparam int DRAIN_CYC  = 2 * MAX_DIM + 16;
   localparam int HOLD_CYC   = 400;
   localparam int RAND_ITEMS = 265;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [socl_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [socl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;

   int   mismatch_total;
   int   outstanding;
   logic calm      = 1'b0;   // no idling on either side while set
   logic hold_go   = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;

   always #5 clock = ~clock;

   spiral_order_cell_locator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   spiral_cell_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_total (mismatch_total),
      .outstanding    (outstanding)
   );

   // Response side: random backpressure, plus one long hold-off once requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYC;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 27);
      end
   end

   task automatic send_item(input logic [socl_pkg::IN_DIM_W-1:0] rows,
                            input logic [socl_pkg::IN_DIM_W-1:0] cols,
                            input logic ccw, input logic [1:0] corner,
                            input logic [socl_pkg::CELL_W-1:0] step);
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {2'b00, step, corner, ccw, cols, rows};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int                            kind;
      logic [socl_pkg::IN_DIM_W-1:0] rows, cols;
      logic [socl_pkg::CELL_W-1:0]   step;
      int                            area;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single cell, empty step, one step past the end
      send_item(11'd1, 11'd1, 1'b0, 2'd0, 21'd1);
      send_item(11'd1, 11'd1, 1'b1, 2'd3, 21'd1);
      send_item(11'd1, 11'd1, 1'b0, 2'd1, 21'd0);
      send_item(11'd1, 11'd1, 1'b1, 2'd2, 21'd2);
      // zero and oversize dimensions
      send_item(11'd0, 11'd5, 1'b0, 2'd0, 21'd1);
      send_item(11'd5, 11'd0, 1'b1, 2'd1, 21'd1);
      send_item(11'd1025, 11'd4, 1'b0, 2'd2, 21'd1);
      send_item(11'd4, 11'd2047, 1'b1, 2'd3, 21'd3);
      send_item(11'd2047, 11'd2047, 1'b1, 2'd3, 21'h1FFFFF);
      // every corner in both turn senses
      for (int i = 0; i < 8; i++)
         send_item(11'd3, 11'd4, i[2], i[1:0], 21'd7);
      send_item(11'd1, 11'd7, 1'b1, 2'd1, 21'd5);
      send_item(11'd6, 11'd1, 1'b0, 2'd2, 21'd6);
      send_item(11'd3, 11'd4, 1'b0, 2'd1, 21'd12);
      send_item(11'd3, 11'd4, 1'b0, 2'd1, 21'd13);
      // largest grid: last cell and one before it; thin grids: last and one past
      send_item(11'd1024, 11'd1024, 1'b0, 2'd0, 21'd1048576);
      send_item(11'd1024, 11'd1024, 1'b1, 2'd2, 21'd1048575);
      send_item(11'd1024, 11'd1, 1'b0, 2'd3, 21'd1024);
      send_item(11'd1, 11'd1024, 1'b1, 2'd0, 21'd1025);

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == 80) calm <= 1'b1;
         if (i == 140) calm <= 1'b0;
         if (i == 160) hold_go <= 1'b1;
         if (i == 220) wait_all_results();
         kind = $urandom_range(99);
         if (kind < 78) begin
            rows = socl_pkg::IN_DIM_W'($urandom_range(12, 1));
            cols = socl_pkg::IN_DIM_W'($urandom_range(12, 1));
         end else if (kind < 88) begin
            rows = socl_pkg::IN_DIM_W'($urandom_range(200, 1));
            cols = socl_pkg::IN_DIM_W'($urandom_range(200, 1));
         end else if (kind < 95) begin
            rows = socl_pkg::IN_DIM_W'($urandom);
            cols = socl_pkg::IN_DIM_W'($urandom);
         end else begin
            rows = socl_pkg::IN_DIM_W'($urandom_range(MAX_DIM, 900));
            cols = socl_pkg::IN_DIM_W'($urandom_range(MAX_DIM, 900));
         end
         area = rows * cols;
         if (kind >= 88 && kind < 95) begin
            step = socl_pkg::CELL_W'($urandom);
         end else if (kind >= 70 && kind < 78) begin
            case ($urandom_range(3))
               0:       step = 21'd0;
               1:       step = 21'd1;
               2:       step = socl_pkg::CELL_W'(area);
               default: step = socl_pkg::CELL_W'(area + 1);
            endcase
         end else begin
            step = socl_pkg::CELL_W'($urandom_range(area, 1));
         end
         send_item(rows, cols, 1'($urandom_range(1)), 2'($urandom_range(3)), step);
      end

      wait_all_results();
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_total == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #25_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/socl_pkg.sv
hw/rtl/spiral_order_cell_locator.sv
tb/spiral_cell_checker.sv
tb/spiral_order_cell_locator_tb.sv
